### hdl/sqlss_pkg.sv
package sqlss_pkg;

    localparam int POS_WIDTH = 24;
    localparam int OUT_POS_W = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RES = 3;
    localparam int RES_IDX_W = $clog2(MAX_RES + 1);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OPEN_STR  = 2'd1;
    localparam logic [1:0] ST_OPEN_CMT  = 2'd2;
    localparam logic [1:0] ST_NO_STMT   = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LF    = 8'h0a;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           out_byte;
        logic                 is_space;
        logic [OUT_POS_W-1:0] start_line;
        logic [OUT_POS_W-1:0] start_column;
        logic [1:0]           status;
        logic                 last;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd11) ||
               (c == 8'd12) || (c == 8'd13);
    endfunction

    function automatic res_t mk_byte(input logic [7:0] c);
        res_t r;
        r = '0;
        r.kind = KIND_BYTE;
        r.out_byte = c;
        r.is_space = is_ws(c);
        return r;
    endfunction

    function automatic res_t mk_end(input logic [POS_WIDTH-1:0] ln,
                                    input logic [POS_WIDTH-1:0] col);
        res_t r;
        r = '0;
        r.kind = KIND_END;
        r.start_line = OUT_POS_W'(ln);
        r.start_column = OUT_POS_W'(col);
        return r;
    endfunction

    function automatic res_t mk_done(input logic [1:0] st);
        res_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.status = st;
        return r;
    endfunction

endpackage

### hdl/sql_statement_splitter_core.sv
// SQL script statement splitter.
// Input stream (s_): one request per script byte (s_tuser = 0, byte in
// s_tdata[7:0]), then one end request (s_tuser = 1) that closes the script.
// Output stream (m_): statement bytes (m_tuser = 0) with a whitespace flag,
// statement ends (m_tuser = 1) carrying the start line and column, and one
// done result (m_tuser = 2) with the status per script. m_tlast marks the last
// result caused by one input request; a request may cause none.
// Path: a request accepted into the input stage is decoded from there into
// the result queue, and its results are read from the head of that queue.
// Throughput: one request per cycle while each request yields at most one
// result; the output side drains one result per cycle while m_tready is high, so
// requests that yield two or three results (a pending '-' or '/' flushed, or the end request)
// hold the input while the queue drains. The limit is the 4-entry result queue,
// which must have room for three results before a request is decoded.
// Reset clears the parse state, the queue and the input stage.
// When the receiver stalls the queue fills and s_tready drops; no result is
// lost or reordered.
module sql_statement_splitter_core
    import sqlss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [7:0] out_byte, [8] is_space, [32:9] start_line,
                                    // [56:33] start_column, [58:57] status, [63:59] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        M_NORMAL, M_PDASH, M_PSLASH, M_LINE, M_BLOCK, M_BSTAR, M_STRING, M_SQUOTE
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [POS_WIDTH-1:0] line_reg, line_next;
    logic [POS_WIDTH-1:0] col_reg, col_next;
    logic                 begun_reg, begun_next;
    logic [POS_WIDTH-1:0] bline_reg, bline_next;
    logic [POS_WIDTH-1:0] bcol_reg, bcol_next;
    logic                 any_reg, any_next;

    logic                 in_vld_reg;
    logic                 in_type_reg;
    logic [7:0]           in_byte_reg;

    res_t                 fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;

    res_t                 res_v [MAX_RES];
    logic [RES_IDX_W-1:0] n_res;

    logic can_push, proc, take, pop;

    assign can_push = cnt_reg <= CNT_W'(FIFO_DEPTH - MAX_RES);
    assign proc     = in_vld_reg && can_push;
    assign s_tready = !in_vld_reg || can_push;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = cnt_reg != '0;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        logic [7:0]           c;
        logic                 do_norm;
        logic [RES_IDX_W-1:0] n;
        c = in_byte_reg;
        do_norm = 1'b0;
        n = '0;
        mode_next = mode_reg;
        line_next = line_reg;
        col_next = col_reg;
        begun_next = begun_reg;
        bline_next = bline_reg;
        bcol_next = bcol_reg;
        any_next = any_reg;
        for (int k = 0; k < MAX_RES; k++) begin
            res_v[k] = '0;
        end

        if (in_type_reg == REQ_END) begin
            if (mode_reg == M_STRING) begin
                res_v[n] = mk_done(ST_OPEN_STR);
                n = n + 1'b1;
            end else if (mode_reg == M_BLOCK || mode_reg == M_BSTAR) begin
                res_v[n] = mk_done(ST_OPEN_CMT);
                n = n + 1'b1;
            end else begin
                if (mode_reg == M_PDASH || mode_reg == M_PSLASH) begin
                    res_v[n] = mk_byte((mode_reg == M_PDASH) ? CH_DASH : CH_SLASH);
                    n = n + 1'b1;
                    begun_next = 1'b1;
                end
                if (begun_next) begin
                    res_v[n] = mk_end(bline_next, bcol_next);
                    n = n + 1'b1;
                    any_next = 1'b1;
                end
                res_v[n] = mk_done(any_next ? ST_OK : ST_NO_STMT);
                n = n + 1'b1;
            end
            mode_next = M_NORMAL;
            line_next = POS_ONE;
            col_next = POS_ONE;
            begun_next = 1'b0;
            bline_next = POS_ONE;
            bcol_next = POS_ONE;
            any_next = 1'b0;
        end else begin
            case (mode_reg)
                M_NORMAL: begin
                    do_norm = 1'b1;
                end
                M_PDASH, M_PSLASH: begin
                    if ((mode_reg == M_PDASH && c == CH_DASH) ||
                        (mode_reg == M_PSLASH && c == CH_STAR)) begin
                        mode_next = (mode_reg == M_PDASH) ? M_LINE : M_BLOCK;
                    end else begin
                        mode_next = M_NORMAL;
                        res_v[n] = mk_byte((mode_reg == M_PDASH) ? CH_DASH : CH_SLASH);
                        n = n + 1'b1;
                        begun_next = 1'b1;
                        do_norm = 1'b1;
                    end
                end
                M_LINE: begin
                    if (c == CH_LF) begin
                        mode_next = M_NORMAL;
                        if (begun_reg) begin
                            res_v[n] = mk_byte(c);
                            n = n + 1'b1;
                        end
                    end
                end
                M_BLOCK: begin
                    if (c == CH_STAR) begin
                        mode_next = M_BSTAR;
                    end else if (c == CH_LF && begun_reg) begin
                        res_v[n] = mk_byte(c);
                        n = n + 1'b1;
                    end
                end
                M_BSTAR: begin
                    if (c == CH_SLASH) begin
                        mode_next = M_NORMAL;
                    end else if (c != CH_STAR) begin
                        mode_next = M_BLOCK;
                        if (c == CH_LF && begun_reg) begin
                            res_v[n] = mk_byte(c);
                            n = n + 1'b1;
                        end
                    end
                end
                M_STRING: begin
                    res_v[n] = mk_byte(c);
                    n = n + 1'b1;
                    if (c == CH_QUOTE) begin
                        mode_next = M_SQUOTE;
                    end
                end
                default: begin
                    if (c == CH_QUOTE) begin
                        res_v[n] = mk_byte(c);
                        n = n + 1'b1;
                        mode_next = M_STRING;
                    end else begin
                        mode_next = M_NORMAL;
                        do_norm = 1'b1;
                    end
                end
            endcase

            if (do_norm) begin
                if (c == CH_QUOTE) begin
                    if (!begun_next) begin
                        bline_next = line_reg;
                        bcol_next = col_reg;
                        begun_next = 1'b1;
                    end
                    res_v[n] = mk_byte(c);
                    n = n + 1'b1;
                    mode_next = M_STRING;
                end else if (c == CH_DASH || c == CH_SLASH) begin
                    if (!begun_next) begin
                        bline_next = line_reg;
                        bcol_next = col_reg;
                    end
                    mode_next = (c == CH_DASH) ? M_PDASH : M_PSLASH;
                end else if (c == CH_SEMI) begin
                    if (begun_next) begin
                        res_v[n] = mk_end(bline_next, bcol_next);
                        n = n + 1'b1;
                        any_next = 1'b1;
                        begun_next = 1'b0;
                    end
                end else begin
                    if (!begun_next && !is_ws(c)) begin
                        bline_next = line_reg;
                        bcol_next = col_reg;
                        begun_next = 1'b1;
                    end
                    if (begun_next) begin
                        res_v[n] = mk_byte(c);
                        n = n + 1'b1;
                    end
                end
            end

            if (c == CH_LF) begin
                if (line_reg != POS_MAX) begin
                    line_next = line_reg + POS_ONE;
                end
                col_next = POS_ONE;
            end else if (col_reg != POS_MAX) begin
                col_next = col_reg + POS_ONE;
            end
        end

        for (int k = 0; k < MAX_RES; k++) begin
            if (RES_IDX_W'(k + 1) == n) begin
                res_v[k].last = 1'b1;
            end
        end
        n_res = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            mode_reg   <= M_NORMAL;
            line_reg   <= POS_ONE;
            col_reg    <= POS_ONE;
            begun_reg  <= 1'b0;
            bline_reg  <= POS_ONE;
            bcol_reg   <= POS_ONE;
            any_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (take) begin
                in_vld_reg <= 1'b1;
            end else if (proc) begin
                in_vld_reg <= 1'b0;
            end
            if (proc) begin
                mode_reg   <= mode_next;
                line_reg   <= line_next;
                col_reg    <= col_next;
                begun_reg  <= begun_next;
                bline_reg  <= bline_next;
                bcol_reg   <= bcol_next;
                any_reg    <= any_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (proc ? CNT_W'(n_res) : '0) - (pop ? CNT_W'(1) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (proc) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (RES_IDX_W'(k) < n_res) begin
                    fifo_reg[wr_ptr_reg + PTR_W'(k)] <= res_v[k];
                end
            end
        end
    end

    res_t head;
    assign head    = fifo_reg[rd_ptr_reg];
    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = 64'({head.status, head.start_column, head.start_line,
                          head.is_space, head.out_byte});

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_end_has_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && in_type_reg == REQ_END) |-> (n_res != '0))
        else $error("end request produced no result");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_type_reg == REQ_END) |=> (mode_reg == M_NORMAL && !begun_reg && !any_reg))
        else $error("parse state not cleared after end request");

    a_space_only_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata[8] == 1'b0 && m_tdata[7:0] == 8'd0))
        else $error("byte fields set on a non-byte result");

endmodule
